// ===== hw/rtl/lvm_pkg.sv =====
// Shared types and constants for the look-at view matrix block.
package lvm_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_BACK  = 2'd2;

  // half an LSB of Q16.16 when rounding a Q32.32 sum
  localparam int RND_HALF = 32768;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [34:0] nvec_t;
  typedef logic signed [17:0] unit_t;
  typedef logic signed [19:0] ax_t;

  typedef struct packed {
    q16_t  [2:0] eye;
    diff_t [2:0] d;
    q16_t  [2:0] up;
  } item_t;

  typedef struct packed {
    logic        start;
    nvec_t [2:0] v;
  } nreq_t;

  typedef struct packed {
    logic        done;
    logic        deg;
    unit_t [2:0] r;
  } nrsp_t;

endpackage

// ===== hw/rtl/lvm_front.sv =====
// Front end: input holding register, eye minus target, push into the queue.
module lvm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lvm_pkg::q16_t eye_x,
  input  lvm_pkg::q16_t eye_y,
  input  lvm_pkg::q16_t eye_z,
  input  lvm_pkg::q16_t target_x,
  input  lvm_pkg::q16_t target_y,
  input  lvm_pkg::q16_t target_z,
  input  lvm_pkg::q16_t up_x,
  input  lvm_pkg::q16_t up_y,
  input  lvm_pkg::q16_t up_z,
  input  logic          q_full,
  output logic          push,
  output lvm_pkg::item_t entry
);
  import lvm_pkg::*;

  logic  hv;
  item_t hold;
  logic  accept;

  assign in_stall = hv && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = hv && !q_full;
  assign entry    = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
    end else begin
      hv <= accept || (hv && q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.eye[0] <= eye_x;
      hold.eye[1] <= eye_y;
      hold.eye[2] <= eye_z;
      hold.d[0]   <= 33'(eye_x) - 33'(target_x);
      hold.d[1]   <= 33'(eye_y) - 33'(target_y);
      hold.d[2]   <= 33'(eye_z) - 33'(target_z);
      hold.up[0]  <= up_x;
      hold.up[1]  <= up_y;
      hold.up[2]  <= up_z;
    end
  end

endmodule

// ===== hw/rtl/lvm_queue.sv =====
// Short FIFO of camera setups between the front end and the back end.
module lvm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lvm_pkg::item_t wdata,
  input  logic           pop,
  output lvm_pkg::item_t head,
  output logic           full,
  output logic           empty
);
  import lvm_pkg::*;

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QAW:0]   cnt;

  assign full  = (cnt == (QAW+1)'(QDEPTH));
  assign empty = (cnt == '0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == QAW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == QAW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

// ===== hw/rtl/lvm_norm.sv =====
// Iterative vector normaliser: range shift, sum of squares, square root, divides.
module lvm_norm (
  input  logic           clk,
  input  logic           rst,
  input  lvm_pkg::nreq_t req,
  output lvm_pkg::nrsp_t rsp
);
  import lvm_pkg::*;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DLOAD = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;

  logic [2:0]  nst;
  logic [33:0] mag [3];
  logic [2:0]  neg;
  logic [33:0] mor;
  logic [1:0]  cnt;
  logic [59:0] prod;
  logic [61:0] sum;
  logic [62:0] root;
  logic [4:0]  jc;
  logic [62:0] sbit;
  logic [62:0] strial;
  logic [31:0] drem;
  logic [16:0] dlow;
  logic [15:0] q;
  logic [4:0]  dc;
  logic [30:0] len;
  logic [46:0] num;
  logic [31:0] dtrial;
  logic        dge;
  logic [16:0] qn;
  logic        done;
  logic        deg;
  unit_t       res [3];
  logic [34:0] amag [3];

  assign mor    = mag[0] | mag[1] | mag[2];
  assign sbit   = 63'(1) << {jc, 1'b0};
  assign strial = root + sbit;
  assign len    = root[30:0];
  assign num    = 47'({mag[cnt][29:0], 16'b0}) + 47'(len[30:1]);
  assign dtrial = {drem[30:0], dlow[16]};
  assign dge    = dtrial >= {1'b0, len};
  assign qn     = {q, dge};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag[i] = req.v[i][34] ? (35'd0 - req.v[i]) : req.v[i];
    end
  end

  assign rsp.done = done;
  assign rsp.deg  = deg;
  assign rsp.r[0] = res[0];
  assign rsp.r[1] = res[1];
  assign rsp.r[2] = res[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      nst  <= N_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (nst)
        N_IDLE: begin
          if (req.start) nst <= N_SHIFT;
        end
        N_SHIFT: begin
          if (mor == '0) begin
            nst  <= N_IDLE;
            done <= 1'b1;
          end else if ((mor[33:30] == '0) && mor[29]) begin
            nst <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt == 2'd3) nst <= N_SQRT;
        end
        N_SQRT: begin
          if (jc == '0) nst <= N_DLOAD;
        end
        N_DLOAD: begin
          nst <= N_DIV;
        end
        N_DIV: begin
          if (dc == 5'd16) begin
            if (cnt == 2'd2) begin
              nst  <= N_IDLE;
              done <= 1'b1;
            end else begin
              nst <= N_DLOAD;
            end
          end
        end
        default: nst <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (nst)
      N_IDLE: begin
        if (req.start) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= amag[i][33:0];
            neg[i] <= req.v[i][34];
          end
          deg <= 1'b0;
        end
      end
      N_SHIFT: begin
        cnt  <= '0;
        sum  <= '0;
        root <= '0;
        jc   <= 5'd31;
        if (mor == '0) begin
          deg <= 1'b1;
          for (int i = 0; i < 3; i++) res[i] <= '0;
        end else if (mor[33:30] != '0) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (!mor[29]) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
      end
      N_SQ: begin
        if (cnt != 2'd3) prod <= mag[cnt][29:0] * mag[cnt][29:0];
        if (cnt != 2'd0) sum <= sum + 62'(prod);
        cnt <= (cnt == 2'd3) ? 2'd0 : cnt + 2'd1;
      end
      N_SQRT: begin
        // one result bit per step, remainder kept in sum
        if ({1'b0, sum} >= strial) begin
          sum  <= sum - strial[61:0];
          root <= (root >> 1) + sbit;
        end else begin
          root <= root >> 1;
        end
        jc <= jc - 5'd1;
      end
      N_DLOAD: begin
        drem <= {2'b0, num[46:17]};
        dlow <= num[16:0];
        q    <= '0;
        dc   <= '0;
      end
      N_DIV: begin
        drem <= dge ? (dtrial - {1'b0, len}) : dtrial;
        dlow <= dlow << 1;
        q    <= qn[15:0];
        dc   <= dc + 5'd1;
        if (dc == 5'd16) begin
          res[cnt] <= neg[cnt] ? (18'd0 - 18'(qn)) : 18'(qn);
          cnt      <= cnt + 2'd1;
        end
      end
      default: ;
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> (nst == N_IDLE))
    else $error("normaliser started while busy");

endmodule

// ===== hw/rtl/lvm_back.sv =====
// Back end: sequences normalisations, cross and dot products, emits the three rows.
module lvm_back (
  input  logic           clk,
  input  logic           rst,
  input  lvm_pkg::item_t head,
  input  logic           q_empty,
  output logic           q_pop,
  output lvm_pkg::nreq_t nreq,
  input  lvm_pkg::nrsp_t nrsp,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     row_index,
  output lvm_pkg::q16_t  col0,
  output lvm_pkg::q16_t  col1,
  output lvm_pkg::q16_t  col2,
  output lvm_pkg::q16_t  col3,
  output logic           degenerate,
  output logic           last_row
);
  import lvm_pkg::*;

  localparam logic [3:0] P_FETCH = 4'd0;
  localparam logic [3:0] P_NZ    = 4'd1;
  localparam logic [3:0] P_NUP   = 4'd2;
  localparam logic [3:0] P_CX    = 4'd3;
  localparam logic [3:0] P_NXS   = 4'd4;
  localparam logic [3:0] P_NX    = 4'd5;
  localparam logic [3:0] P_CY    = 4'd6;
  localparam logic [3:0] P_DOT   = 4'd7;
  localparam logic [3:0] P_EMIT  = 4'd8;

  logic [3:0] ph;
  logic [3:0] st;
  logic [1:0] er;
  q16_t       eye [3];
  q16_t       up  [3];
  unit_t      z   [3];
  unit_t      upn [3];
  unit_t      x   [3];
  ax_t        y   [3];
  nvec_t      c   [3];
  q16_t       tr  [3];
  logic       degen;

  // multiply-accumulate pipeline
  logic signed [51:0] prod;
  logic signed [53:0] acc;
  logic signed [53:0] acc_base;
  logic signed [53:0] acc_next;
  logic               p_vld, p_first, p_last, p_rnd;
  logic [1:0]         p_dst;

  logic        is_mac, issue;
  logic [3:0]  nsteps;
  logic [1:0]  ci, cj, ck, drow, dcomp;
  logic [3:0]  dsub;
  ax_t         av [3];
  ax_t         bv [3];
  ax_t         dax [3];
  ax_t         opa;
  q16_t        opb;
  logic        o_first, o_last, o_rnd;
  logic [1:0]  o_dst;
  logic signed [37:0] tq;
  q16_t        tsat;
  logic        ofree;
  logic        store;

  always_comb begin
    is_mac = (ph == P_CX) || (ph == P_CY) || (ph == P_DOT);
    nsteps = (ph == P_DOT) ? 4'd9 : 4'd6;
    issue  = is_mac && (st < nsteps);
    ci     = (st[2:1] == 2'd3) ? 2'd2 : st[2:1];
    cj     = (ci == 2'd2) ? 2'd0 : ci + 2'd1;
    ck     = (ci == 2'd0) ? 2'd2 : ci - 2'd1;
    drow   = (st >= 4'd6) ? 2'd2 : ((st >= 4'd3) ? 2'd1 : 2'd0);
    dsub   = (drow == 2'd2) ? 4'd6 : ((drow == 2'd1) ? 4'd3 : 4'd0);
    dcomp  = 2'(st - dsub);
    if (dcomp == 2'd3) dcomp = 2'd2;
    for (int i = 0; i < 3; i++) begin
      av[i]  = (ph == P_CX) ? ax_t'(upn[i]) : ax_t'(z[i]);
      bv[i]  = (ph == P_CX) ? ax_t'(z[i]) : ax_t'(x[i]);
      dax[i] = (drow == ROW_RIGHT) ? ax_t'(x[i]) :
               ((drow == ROW_UP) ? y[i] : ax_t'(z[i]));
    end
    if (ph == P_DOT) begin
      opa     = -dax[dcomp];
      opb     = eye[dcomp];
      o_first = (dcomp == 2'd0);
      o_last  = (dcomp == 2'd2);
      o_dst   = drow;
      o_rnd   = 1'b1;
    end else if (!st[0]) begin
      opa     = av[cj];
      opb     = q16_t'(bv[ck]);
      o_first = 1'b1;
      o_last  = 1'b0;
      o_dst   = ci;
      o_rnd   = (ph == P_CY);
    end else begin
      opa     = -av[ck];
      opb     = q16_t'(bv[cj]);
      o_first = 1'b0;
      o_last  = 1'b1;
      o_dst   = ci;
      o_rnd   = (ph == P_CY);
    end
  end

  // rounding half folded into the start of the sum
  assign acc_base = p_first ? (p_rnd ? 54'(RND_HALF) : 54'sd0) : acc;
  assign acc_next = acc_base + 54'(prod);
  assign store    = p_vld && p_last;
  assign tq       = acc_next[53:16];

  always_comb begin
    if (tq[37:31] == {7{tq[31]}}) tsat = tq[31:0];
    else if (tq[37]) tsat = 32'sh8000_0000;
    else tsat = 32'sh7fff_ffff;
  end

  assign ofree = !out_valid || !out_stall;

  always_comb begin
    q_pop      = 1'b0;
    nreq.start = 1'b0;
    for (int i = 0; i < 3; i++) nreq.v[i] = c[i];
    case (ph)
      P_FETCH: begin
        q_pop      = !q_empty;
        nreq.start = !q_empty;
        for (int i = 0; i < 3; i++) nreq.v[i] = 35'($signed(head.d[i]));
      end
      P_NZ: begin
        nreq.start = nrsp.done;
        for (int i = 0; i < 3; i++) nreq.v[i] = 35'(up[i]);
      end
      P_NXS: nreq.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph        <= P_FETCH;
      st        <= '0;
      er        <= '0;
      p_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_vld <= issue;
      if (issue) st <= st + 4'd1;
      if (ofree && (ph == P_EMIT)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (ph)
        P_FETCH: if (!q_empty) ph <= P_NZ;
        P_NZ:    if (nrsp.done) ph <= P_NUP;
        P_NUP: begin
          if (nrsp.done) begin
            ph <= P_CX;
            st <= '0;
          end
        end
        P_CX:  if (store && (p_dst == 2'd2)) ph <= P_NXS;
        P_NXS: ph <= P_NX;
        P_NX: begin
          if (nrsp.done) begin
            ph <= P_CY;
            st <= '0;
          end
        end
        P_CY: begin
          if (store && (p_dst == 2'd2)) begin
            ph <= P_DOT;
            st <= '0;
          end
        end
        P_DOT: if (store && (p_dst == 2'd2)) ph <= P_EMIT;
        P_EMIT: begin
          if (ofree) begin
            er <= (er == ROW_BACK) ? ROW_RIGHT : er + 2'd1;
            if (er == ROW_BACK) ph <= P_FETCH;
          end
        end
        default: ph <= P_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod    <= opa * opb;
      p_first <= o_first;
      p_last  <= o_last;
      p_rnd   <= o_rnd;
      p_dst   <= o_dst;
    end
    if (p_vld) acc <= acc_next;
    if (store) begin
      case (ph)
        P_CX:    c[p_dst]  <= acc_next[34:0];
        P_CY:    y[p_dst]  <= acc_next[35:16];
        P_DOT:   tr[p_dst] <= tsat;
        default: ;
      endcase
    end
    case (ph)
      P_FETCH: begin
        if (!q_empty) begin
          for (int i = 0; i < 3; i++) begin
            eye[i] <= head.eye[i];
            up[i]  <= head.up[i];
          end
          degen <= 1'b0;
        end
      end
      P_NZ: begin
        if (nrsp.done) begin
          for (int i = 0; i < 3; i++) z[i] <= nrsp.r[i];
          degen <= degen | nrsp.deg;
        end
      end
      P_NUP: begin
        if (nrsp.done) begin
          for (int i = 0; i < 3; i++) upn[i] <= nrsp.r[i];
          degen <= degen | nrsp.deg;
        end
      end
      P_NX: begin
        if (nrsp.done) begin
          for (int i = 0; i < 3; i++) x[i] <= nrsp.r[i];
          degen <= degen | nrsp.deg;
        end
      end
      P_EMIT: begin
        if (ofree) begin
          row_index  <= er;
          degenerate <= degen;
          last_row   <= (er == ROW_BACK);
          col3       <= tr[er];
          if (er == ROW_RIGHT) begin
            col0 <= q16_t'(x[0]);
            col1 <= q16_t'(x[1]);
            col2 <= q16_t'(x[2]);
          end else if (er == ROW_UP) begin
            col0 <= q16_t'(y[0]);
            col1 <= q16_t'(y[1]);
            col2 <= q16_t'(y[2]);
          end else begin
            col0 <= q16_t'(z[0]);
            col1 <= q16_t'(z[1]);
            col2 <= q16_t'(z[2]);
          end
        end
      end
      default: ;
    endcase
  end

  a_last_row: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (last_row == (row_index == ROW_BACK)))
    else $error("last_row out of step with row_index");
  a_row_code: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (row_index == ROW_RIGHT || row_index == ROW_UP || row_index == ROW_BACK))
    else $error("row_index out of range");

endmodule

// ===== hw/rtl/lookat_view_matrix.sv =====
// Look-at view matrix: camera setup in, three matrix rows out.
//
// Input channel: in_valid/in_stall with eye, target and up vectors in signed
// Q16.16. Output channel: out_valid/out_stall, one word per matrix row, rows
// 0 (right), 1 (up), 2 (back) in order, last_row set on row 2. Each row
// carries the axis and the saturated negated dot of the axis with the eye.
// A zero-length vector sets degenerate on all three rows of that setup.
// Setups are queued (four deep plus a holding register), so the input keeps
// accepting while the back end is busy or the output is stalled, until both
// the queue and the holding register are full. Row 1 and row 2 follow row 0
// unless the output stalls. Throughput is set by the single iterative
// normaliser, run three times per setup (range-shift steps, a square root
// and three divides), plus the cross products, a dot pass and the rows; the
// back end fetches the next setup only after putting out the last row of the
// previous one. A degenerate vector skips most of its normaliser run.
// Reset clears the queue and all control state; no output word is valid
// afterwards. When out_stall is high the current row holds and the back end
// waits; if that row is row 2 it first works through the next queued setup.
// The queue fills until in_stall rises.
module lookat_view_matrix (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lvm_pkg::q16_t eye_x,
  input  lvm_pkg::q16_t eye_y,
  input  lvm_pkg::q16_t eye_z,
  input  lvm_pkg::q16_t target_x,
  input  lvm_pkg::q16_t target_y,
  input  lvm_pkg::q16_t target_z,
  input  lvm_pkg::q16_t up_x,
  input  lvm_pkg::q16_t up_y,
  input  lvm_pkg::q16_t up_z,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    row_index,
  output lvm_pkg::q16_t col0,
  output lvm_pkg::q16_t col1,
  output lvm_pkg::q16_t col2,
  output lvm_pkg::q16_t col3,
  output logic          degenerate,
  output logic          last_row
);
  import lvm_pkg::*;

  logic  push, pop, q_full, q_empty;
  item_t entry, head;
  nreq_t nreq;
  nrsp_t nrsp;

  lvm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .eye_x    (eye_x),
    .eye_y    (eye_y),
    .eye_z    (eye_z),
    .target_x (target_x),
    .target_y (target_y),
    .target_z (target_z),
    .up_x     (up_x),
    .up_y     (up_y),
    .up_z     (up_z),
    .q_full   (q_full),
    .push     (push),
    .entry    (entry)
  );

  lvm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry),
    .pop   (pop),
    .head  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  lvm_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (nreq),
    .rsp (nrsp)
  );

  lvm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (pop),
    .nreq       (nreq),
    .nrsp       (nrsp),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_index  (row_index),
    .col0       (col0),
    .col1       (col1),
    .col2       (col2),
    .col3       (col3),
    .degenerate (degenerate),
    .last_row   (last_row)
  );

endmodule

// ===== verif/lookat_view_matrix_tb.sv =====
// Testbench for the look-at view matrix block: random and directed camera setups.
`timescale 1ns / 1ps

module lookat_view_matrix_tb;
  import lvm_pkg::*;

  typedef struct {
    logic [1:0] row;
    q16_t       c0, c1, c2, c3;
    logic       deg, last;
  } row_word_t;

  class row_scoreboard;
    row_word_t pending[$];
    int        mismatches;

    // normalise; returns 1 on zero length
    function automatic bit unit_vec(input longint v[3], output longint o[3]);
      longint unsigned mag[3], mx, sum, len, r, b, n;
      bit neg[3];
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i] < 0;
        mag[i] = neg[i] ? -v[i] : v[i];
        if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
        o[0] = 0; o[1] = 0; o[2] = 0;
        return 1;
      end
      while (mx >= 64'd1 << 30) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (mx < 64'd1 << 29) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      n = sum; r = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b; r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      len = r;
      for (int i = 0; i < 3; i++) begin
        longint q;
        q = longint'((mag[i] * 65536 + len / 2) / len);
        o[i] = neg[i] ? -q : q;
      end
      return 0;
    endfunction

    function automatic longint to_q16(input longint v);
      return (v + RND_HALF) >>> 16;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function void note_setup(input q16_t e[3], input q16_t t[3], input q16_t u[3]);
      longint eye[3], d[3], up[3], upn[3], z[3], c[3], x[3], yq[3], y[3], ax[3];
      longint dot, tr;
      bit deg;
      row_word_t w;
      for (int i = 0; i < 3; i++) begin
        eye[i] = e[i];
        d[i] = longint'(e[i]) - longint'(t[i]);
        up[i] = u[i];
      end
      deg = unit_vec(d, z);
      deg |= unit_vec(up, upn);
      cross3(upn, z, c);
      deg |= unit_vec(c, x);
      cross3(z, x, yq);
      for (int i = 0; i < 3; i++) y[i] = to_q16(yq[i]);
      for (int k = 0; k < 3; k++) begin
        case (k)
          0:       ax = x;
          1:       ax = y;
          default: ax = z;
        endcase
        dot = ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2];
        tr = to_q16(-dot);
        if (tr > 64'sh7FFFFFFF) tr = 64'sh7FFFFFFF;
        if (tr < -64'sh80000000) tr = -64'sh80000000;
        w.row  = (k == 0) ? ROW_RIGHT : (k == 1) ? ROW_UP : ROW_BACK;
        w.c0 = ax[0][31:0]; w.c1 = ax[1][31:0]; w.c2 = ax[2][31:0];
        w.c3 = tr[31:0];
        w.deg = deg; w.last = (k == 2);
        pending.push_back(w);
      end
    endfunction

    function void check_row(input row_word_t got);
      row_word_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row word, row %0d", got.row);
        return;
      end
      exp = pending.pop_front();
      if (got.row !== exp.row || got.c0 !== exp.c0 || got.c1 !== exp.c1 ||
          got.c2 !== exp.c2 || got.c3 !== exp.c3 || got.deg !== exp.deg ||
          got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row mismatch exp %0d %0d %0d %0d %0d d%b l%b got %0d %0d %0d %0d %0d d%b l%b",
                   exp.row, exp.c0, exp.c1, exp.c2, exp.c3, exp.deg, exp.last,
                   got.row, got.c0, got.c1, got.c2, got.c3, got.deg, got.last);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid, degenerate, last_row;
  logic [1:0] row_index;
  q16_t eye_x = 0, eye_y = 0, eye_z = 0, target_x = 0, target_y = 0, target_z = 0;
  q16_t up_x = 0, up_y = 0, up_z = 0, col0, col1, col2, col3;

  int send_idle_pct = 33, recv_idle_pct = 77;
  bit hold_off = 0;
  row_scoreboard rows = new();

  lookat_view_matrix dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        rows.note_setup('{eye_x, eye_y, eye_z}, '{target_x, target_y, target_z},
                        '{up_x, up_y, up_z});
      if (out_valid && !out_stall)
        rows.check_row('{row_index, col0, col1, col2, col3, degenerate, last_row});
    end
  end

  // receiver stall, one assignment per falling edge
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  function automatic q16_t rand_field();
    case ($urandom_range(5))
      0: return q16_t'($urandom);
      1: return q16_t'(32'h7FFFFFFF);
      2: return q16_t'(32'h80000000);
      3: return q16_t'($urandom_range(131072)) - 65536;
      default: return q16_t'($urandom_range(1 << 24)) - (1 << 23);
    endcase
  endfunction

  // offer one setup and hold it until taken; valid stays up for the next word
  task automatic send_setup(input q16_t e[3], input q16_t t[3], input q16_t u[3]);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    eye_x <= e[0]; eye_y <= e[1]; eye_z <= e[2];
    target_x <= t[0]; target_y <= t[1]; target_z <= t[2];
    up_x <= u[0]; up_y <= u[1]; up_z <= u[2];
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic end_send();
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic send_random(input int n);
    q16_t e[3], t[3], u[3];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        e[i] = rand_field(); t[i] = rand_field(); u[i] = rand_field();
      end
      case ($urandom_range(9))
        0: t = e;                                     // eye on target
        1: u = '{0, 0, 0};                             // no up vector
        2: for (int i = 0; i < 3; i++) u[i] = e[i] - t[i]; // up along view
        default: ;
      endcase
      send_setup(e, t, u);
    end
  endtask

  localparam q16_t MAXV = 32'h7FFFFFFF;
  localparam q16_t MINV = 32'h80000000;

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_setup('{0, 0, 5 << 16}, '{0, 0, 0}, '{0, 1 << 16, 0});
    send_setup('{1, 2, 3}, '{1, 2, 3}, '{0, 1 << 16, 0});
    send_setup('{3 << 16, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
    send_setup('{0, 4 << 16, 0}, '{0, 0, 0}, '{0, 1 << 16, 0});
    send_setup('{0, 4 << 16, 0}, '{0, 0, 0}, '{0, -2, 0});
    send_setup('{MAXV, MAXV, MAXV}, '{MINV, MINV, MINV}, '{MAXV, 0, MINV});
    send_setup('{MINV, MINV, MINV}, '{MAXV, MAXV, MAXV}, '{MINV, MAXV, 0});
    send_setup('{MAXV, MINV, MAXV}, '{0, 0, 0}, '{1, 0, 0});
    send_setup('{1, 0, 0}, '{0, 0, 0}, '{0, 0, 1});
    send_setup('{-1, -1, -1}, '{MAXV, 0, MINV}, '{-1, -1, 0});
    send_random(110);
    send_idle_pct = 77; recv_idle_pct = 33;
    send_random(110);
    send_idle_pct = 0; recv_idle_pct = 0;
    // long receiver hold-off so the queue backs up
    hold_off = 1;
    fork
      begin
        repeat (6000) @(posedge clk);
        hold_off = 0;
      end
      begin
        send_random(10);
        end_send();
      end
    join
    send_random(120);
    end_send();
    while (rows.pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (rows.mismatches == 0 && rows.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/lvm_pkg.sv
hw/rtl/lvm_front.sv
hw/rtl/lvm_queue.sv
hw/rtl/lvm_norm.sv
hw/rtl/lvm_back.sv
hw/rtl/lookat_view_matrix.sv
verif/lookat_view_matrix_tb.sv
